// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the depth-to-point top design file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DPP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define DPP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DPP_ASSERT(lbl, clk, rst, prop)
`define DPP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/dpp_pkg.sv -----
// ---------------------------------------------------------------------------
// Depth pixel to 3D point package
// Field widths, register codes and reset values used by the top design file.
// ---------------------------------------------------------------------------
package dpp_pkg;

   localparam int COORD_BITS_DEF = 12;

   localparam int COL_W    = 12;
   localparam int DEPTH_W  = 16;
   localparam int CENTER_W = 13;
   localparam int FOCAL_W  = 16;
   localparam int PX_W     = 26;
   localparam int PZ_W     = 24;
   localparam int OUT_FRAC = 8;
   localparam int FOCAL_FRAC = 4;
   localparam int FIX_TOTAL = 30;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_X  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_Y  = 2'd3;

   localparam logic [FOCAL_W-1:0] FOCAL_MIN   = 16'd16;
   localparam logic [FOCAL_W-1:0] FOCAL_X_RST = 16'd11891;
   localparam logic [FOCAL_W-1:0] FOCAL_Y_RST = 16'd11874;

endpackage

// ----- design/dpp_div_chain.sv -----
// ---------------------------------------------------------------------------
// Divider cell chain
// Restoring division, one quotient bit per cell; each cell registers its
// partial remainder and hands it to the next cell on every enabled cycle.
// ---------------------------------------------------------------------------
module dpp_div_chain #(
   parameter int QUOT_W = 24,
   parameter int DIV_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [QUOT_W+DIV_W-1:0]    in_num,
   input  logic [DIV_W-1:0]           in_div,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [QUOT_W-1:0]          out_quot,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int NUM_W = QUOT_W + DIV_W;

   logic [QUOT_W-1:0] valid_ff;
   logic [DIV_W-1:0]  rem_ff  [QUOT_W];
   logic [QUOT_W-1:0] low_ff  [QUOT_W];
   logic [QUOT_W-1:0] quot_ff [QUOT_W];
   logic [DIV_W-1:0]  div_ff  [QUOT_W];
   logic [SIDE_W-1:0] side_ff [QUOT_W];

   for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
      logic              valid_prev;
      logic [DIV_W-1:0]  rem_prev;
      logic [QUOT_W-1:0] low_prev;
      logic [QUOT_W-1:0] quot_prev;
      logic [DIV_W-1:0]  div_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DIV_W:0]    trial;
      logic [DIV_W:0]    diff;
      logic              ge;
      logic [DIV_W-1:0]  rem_in;
      logic [QUOT_W-1:0] quot_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_num[NUM_W-1:QUOT_W];
         assign low_prev   = in_num[QUOT_W-1:0];
         assign quot_prev  = '0;
         assign div_prev   = in_div;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign low_prev   = low_ff[i-1];
         assign quot_prev  = quot_ff[i-1];
         assign div_prev   = div_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      // The remainder always stays below the divisor, so the shifted trial
      // value needs only one extra bit.
      always_comb begin
         trial   = {rem_prev, low_prev[QUOT_W-1]};
         diff    = trial - {1'b0, div_prev};
         ge      = (trial >= {1'b0, div_prev});
         rem_in  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quot_in = QUOT_W'({quot_prev, ge});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            low_ff[i]  <= low_prev << 1;
            quot_ff[i] <= quot_in;
            div_ff[i]  <= div_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

// ----- design/dpp_sqrt_chain.sv -----
// ---------------------------------------------------------------------------
// Square root cell chain
// Digit-by-digit integer square root, one root bit per cell; each cell
// registers its partial root and remainder for the next cell.
// ---------------------------------------------------------------------------
module dpp_sqrt_chain #(
   parameter int ROOT_W = 32,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [ROOT_W-1:0] valid_ff;
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      logic              valid_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  sub;
      logic [REM_W+1:0]  diff;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign rad_prev   = in_rad;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign rad_prev   = rad_ff[i-1];
         assign root_prev  = root_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      // Bring down the next two radicand bits and try 4*root + 1.
      always_comb begin
         trial   = {rem_prev, rad_prev[RAD_W-1:RAD_W-2]};
         sub     = (REM_W+2)'({root_prev, 2'b01});
         diff    = trial - sub;
         ge      = (trial >= sub);
         rem_in  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
         root_in = ROOT_W'({root_prev, ge});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            rad_ff[i]  <= rad_prev << 2;
            root_ff[i] <= root_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ----- design/depth_pixel_to_3d_point_top.sv -----
// ---------------------------------------------------------------------------
// Depth pixel to 3D point
// Pinhole back-projection with depth taken along the normalized pixel ray.
// ---------------------------------------------------------------------------
// Usage: each item on the req_ channel is one depth pixel (column, row,
// depth); each item on the rsp_ channel is the matching 3D point in fixed
// point with 8 fraction bits, x and y signed and z unsigned, in the same
// order. Both channels use valid and stall; an item moves when valid is
// high and stall is low. Projection center and focal lengths are written
// through the csr_ port, which is always ready; the user must write them
// only while no item is in flight, the block itself does not enforce it.
// Throughput: one item per clock while req_stall is low. The pipeline is
// made of the ray divider chains (QW cells), the square root chain (RW
// cells), the point divider chains (24 cells) and six register stages
// around them; QW = max(COORD_BITS + 1, 13) + 30 - COORD_BITS, RW = QW + 1.
// Reset clears all item valid bits and restores the register defaults.
// When the receiver stalls, the output register holds its item and a skid
// register catches one more; the pipeline then freezes and req_stall rises
// until the skid register drains.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_pixel_to_3d_point_top #(
   parameter int COORD_BITS = dpp_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dpp_pkg::COL_W-1:0]             req_column,
   input  logic [dpp_pkg::COL_W-1:0]             req_row,
   input  logic [dpp_pkg::DEPTH_W-1:0]           req_depth,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dpp_pkg::PX_W-1:0]       rsp_point_x,
   output logic signed [dpp_pkg::PX_W-1:0]       rsp_point_y,
   output logic [dpp_pkg::PZ_W-1:0]              rsp_point_z,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dpp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dpp_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int CB    = COORD_BITS;
   localparam int UF    = dpp_pkg::FIX_TOTAL - CB;
   localparam int MAG_W = (CB > 12) ? CB + 1 : 13;
   localparam int QW    = MAG_W + UF;
   localparam int RW    = QW + 1;
   localparam int DW    = dpp_pkg::DEPTH_W;
   localparam int CW    = dpp_pkg::CENTER_W;
   localparam int FW    = dpp_pkg::FOCAL_W;
   localparam int PZW   = dpp_pkg::PZ_W;
   localparam int PXW   = dpp_pkg::PX_W;
   localparam int U_NW  = QW + FW;
   localparam int P_NW  = PZW + RW;
   localparam int PROD_W = DW + QW;
   localparam int SQ_SIDE_W = 2 * QW + DW + 2;

   // Configuration registers
   logic [CW-1:0] center_x_ff;
   logic [CW-1:0] center_y_ff;
   logic [FW-1:0] focal_x_ff;
   logic [FW-1:0] focal_y_ff;
   logic [FW-1:0] focal_x_eff;
   logic [FW-1:0] focal_y_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         focal_x_ff  <= dpp_pkg::FOCAL_X_RST;
         focal_y_ff  <= dpp_pkg::FOCAL_Y_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            dpp_pkg::REG_CENTER_X: center_x_ff <= csr_data[CW-1:0];
            dpp_pkg::REG_CENTER_Y: center_y_ff <= csr_data[CW-1:0];
            dpp_pkg::REG_FOCAL_X:  focal_x_ff  <= csr_data[FW-1:0];
            dpp_pkg::REG_FOCAL_Y:  focal_y_ff  <= csr_data[FW-1:0];
         endcase
      end
   end

   // Focal lengths below 1.0 act as 1.0.
   assign focal_x_eff = (focal_x_ff < dpp_pkg::FOCAL_MIN) ? dpp_pkg::FOCAL_MIN : focal_x_ff;
   assign focal_y_eff = (focal_y_ff < dpp_pkg::FOCAL_MIN) ? dpp_pkg::FOCAL_MIN : focal_y_ff;

   // Pipeline enable: everything moves unless the skid register is full.
   logic skid_full_ff;
   logic en;
   assign en        = ~skid_full_ff;
   assign req_stall = skid_full_ff;

   // Stage 0: input register
   logic          v0_ff;
   logic [CB-1:0] col_ff;
   logic [CB-1:0] row_ff;
   logic [DW-1:0] depth0_ff;
   logic [CB-1:0] col_sel;
   logic [CB-1:0] row_sel;

   if (CB <= dpp_pkg::COL_W) begin : g_coord_narrow
      assign col_sel = req_column[CB-1:0];
      assign row_sel = req_row[CB-1:0];
   end else begin : g_coord_wide
      assign col_sel = CB'(req_column);
      assign row_sel = CB'(req_row);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff    <= col_sel;
         row_ff    <= row_sel;
         depth0_ff <= req_depth;
      end
   end

   // Stage 1: offsets from the projection center, split into sign and size
   logic signed [MAG_W:0] dx;
   logic signed [MAG_W:0] dy;
   logic [MAG_W:0]        dx_neg;
   logic [MAG_W:0]        dy_neg;
   logic                  v1_ff;
   logic [MAG_W-1:0]      mx_ff;
   logic [MAG_W-1:0]      my_ff;
   logic                  sx1_ff;
   logic                  sy1_ff;
   logic [DW-1:0]         depth1_ff;

   always_comb begin
      dx = $signed({{(MAG_W+1-CB){1'b0}}, col_ff})
         - $signed({{(MAG_W+1-CW){center_x_ff[CW-1]}}, center_x_ff});
      dy = $signed({{(MAG_W+1-CB){1'b0}}, row_ff})
         - $signed({{(MAG_W+1-CW){center_y_ff[CW-1]}}, center_y_ff});
      dx_neg = -dx;
      dy_neg = -dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff     <= dx[MAG_W] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
         my_ff     <= dy[MAG_W] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];
         sx1_ff    <= dx[MAG_W];
         sy1_ff    <= dy[MAG_W];
         depth1_ff <= depth0_ff;
      end
   end

   // Ray components: |d| * 16 / focal in Q.UF, rounded
   logic [U_NW-1:0] u_num;
   logic [U_NW-1:0] v_num;
   logic            uv_valid;
   logic            vv_valid;
   logic [QW-1:0]   um_q;
   logic [QW-1:0]   vm_q;
   logic [DW:0]     u_side;
   logic            v_side;

   assign u_num = U_NW'({mx_ff, {(dpp_pkg::FOCAL_FRAC+UF){1'b0}}}) + U_NW'(focal_x_eff[FW-1:1]);
   assign v_num = U_NW'({my_ff, {(dpp_pkg::FOCAL_FRAC+UF){1'b0}}}) + U_NW'(focal_y_eff[FW-1:1]);

   dpp_div_chain #(.QUOT_W(QW), .DIV_W(FW), .SIDE_W(DW + 1)) u_div_u (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_num    (u_num),
      .in_div    (focal_x_eff),
      .in_side   ({depth1_ff, sx1_ff}),
      .out_valid (uv_valid),
      .out_quot  (um_q),
      .out_side  (u_side)
   );

   dpp_div_chain #(.QUOT_W(QW), .DIV_W(FW), .SIDE_W(1)) u_div_v (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_num    (v_num),
      .in_div    (focal_y_eff),
      .in_side   (sy1_ff),
      .out_valid (vv_valid),
      .out_quot  (vm_q),
      .out_side  (v_side)
   );

   // Stage 2: squares
   logic            v2_ff;
   logic [2*QW-1:0] squ_ff;
   logic [2*QW-1:0] sqv_ff;
   logic [QW-1:0]   um2_ff;
   logic [QW-1:0]   vm2_ff;
   logic [DW-1:0]   depth2_ff;
   logic            sx2_ff;
   logic            sy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= uv_valid & vv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         squ_ff    <= um_q * um_q;
         sqv_ff    <= vm_q * vm_q;
         um2_ff    <= um_q;
         vm2_ff    <= vm_q;
         depth2_ff <= u_side[DW:1];
         sx2_ff    <= u_side[0];
         sy2_ff    <= v_side;
      end
   end

   // Stage 3: squared length u*u + v*v + 1.0 in Q.2UF
   logic            v3_ff;
   logic [2*RW-1:0] s_ff;
   logic [SQ_SIDE_W-1:0] side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff     <= (2*RW)'(squ_ff) + (2*RW)'(sqv_ff) + ((2*RW)'(1) << (2 * UF));
         side3_ff <= {um2_ff, vm2_ff, depth2_ff, sx2_ff, sy2_ff};
      end
   end

   // Ray length
   logic                 n_valid;
   logic [RW-1:0]        n_root;
   logic [SQ_SIDE_W-1:0] n_side;

   dpp_sqrt_chain #(.ROOT_W(RW), .SIDE_W(SQ_SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (s_ff),
      .in_side   (side3_ff),
      .out_valid (n_valid),
      .out_root  (n_root),
      .out_side  (n_side)
   );

   // Stage 4: depth times ray components
   logic              v4_ff;
   logic [PROD_W-1:0] px_ff;
   logic [PROD_W-1:0] py_ff;
   logic [RW-1:0]     n_ff;
   logic [DW-1:0]     depth4_ff;
   logic              sx4_ff;
   logic              sy4_ff;
   logic [QW-1:0]     um_n;
   logic [QW-1:0]     vm_n;
   logic [DW-1:0]     depth_n;

   assign um_n    = n_side[SQ_SIDE_W-1 -: QW];
   assign vm_n    = n_side[DW+2+QW-1 -: QW];
   assign depth_n = n_side[DW+1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= n_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff     <= depth_n * um_n;
         py_ff     <= depth_n * vm_n;
         n_ff      <= n_root;
         depth4_ff <= depth_n;
         sx4_ff    <= n_side[1];
         sy4_ff    <= n_side[0];
      end
   end

   // Point components: rounded quotients by the ray length
   logic [P_NW-1:0] x_num;
   logic [P_NW-1:0] y_num;
   logic [P_NW-1:0] z_num;
   logic            xv_valid;
   logic            yv_valid;
   logic            zv_valid;
   logic [PZW-1:0]  qx;
   logic [PZW-1:0]  qy;
   logic [PZW-1:0]  qz;
   logic            sx_q;
   logic            sy_q;
   logic            zero_q;

   assign x_num = P_NW'({px_ff, {dpp_pkg::OUT_FRAC{1'b0}}}) + P_NW'(n_ff[RW-1:1]);
   assign y_num = P_NW'({py_ff, {dpp_pkg::OUT_FRAC{1'b0}}}) + P_NW'(n_ff[RW-1:1]);
   assign z_num = P_NW'({depth4_ff, {(dpp_pkg::OUT_FRAC+UF){1'b0}}}) + P_NW'(n_ff[RW-1:1]);

   dpp_div_chain #(.QUOT_W(PZW), .DIV_W(RW), .SIDE_W(1)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_num    (x_num),
      .in_div    (n_ff),
      .in_side   (sx4_ff),
      .out_valid (xv_valid),
      .out_quot  (qx),
      .out_side  (sx_q)
   );

   dpp_div_chain #(.QUOT_W(PZW), .DIV_W(RW), .SIDE_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_num    (y_num),
      .in_div    (n_ff),
      .in_side   (sy4_ff),
      .out_valid (yv_valid),
      .out_quot  (qy),
      .out_side  (sy_q)
   );

   dpp_div_chain #(.QUOT_W(PZW), .DIV_W(RW), .SIDE_W(1)) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_num    (z_num),
      .in_div    (n_ff),
      .in_side   (depth4_ff == '0),
      .out_valid (zv_valid),
      .out_quot  (qz),
      .out_side  (zero_q)
   );

   // Apply signs, add the center back to x and y, and zero z for zero depth.
   logic           pipe_valid;
   logic [PXW-1:0] new_x;
   logic [PXW-1:0] new_y;
   logic [PZW-1:0] new_z;
   logic [PXW-1:0] cx_fix;
   logic [PXW-1:0] cy_fix;

   always_comb begin
      pipe_valid = xv_valid & yv_valid & zv_valid;
      cx_fix = {{(PXW-CW-dpp_pkg::OUT_FRAC){center_x_ff[CW-1]}}, center_x_ff,
                {dpp_pkg::OUT_FRAC{1'b0}}};
      cy_fix = {{(PXW-CW-dpp_pkg::OUT_FRAC){center_y_ff[CW-1]}}, center_y_ff,
                {dpp_pkg::OUT_FRAC{1'b0}}};
      new_x  = (sx_q ? -PXW'(qx) : PXW'(qx)) + cx_fix;
      new_y  = (sy_q ? -PXW'(qy) : PXW'(qy)) + cy_fix;
      new_z  = zero_q ? '0 : qz;
   end

   // Output register with one skid entry
   logic           rsp_valid_ff;
   logic [PXW-1:0] out_x_ff;
   logic [PXW-1:0] out_y_ff;
   logic [PZW-1:0] out_z_ff;
   logic [PXW-1:0] skid_x_ff;
   logic [PXW-1:0] skid_y_ff;
   logic [PZW-1:0] skid_z_ff;
   logic           rsp_valid_in;
   logic           skid_full_in;
   logic           load_from_pipe;
   logic           load_from_skid;
   logic           load_skid;
   logic           taken;
   logic           emit;

   always_comb begin
      taken          = rsp_valid_ff & ~rsp_stall;
      emit           = en & pipe_valid;
      load_from_skid = taken & skid_full_ff;
      load_from_pipe = (taken & ~skid_full_ff) | ~rsp_valid_ff;
      load_skid      = rsp_valid_ff & rsp_stall & emit;
      rsp_valid_in   = rsp_valid_ff;
      skid_full_in   = skid_full_ff;
      if (load_from_skid) begin
         skid_full_in = 1'b0;
      end else if (load_from_pipe) begin
         rsp_valid_in = emit;
      end else if (load_skid) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_from_skid) begin
         out_x_ff <= skid_x_ff;
         out_y_ff <= skid_y_ff;
         out_z_ff <= skid_z_ff;
      end else if (load_from_pipe) begin
         out_x_ff <= new_x;
         out_y_ff <= new_y;
         out_z_ff <= new_z;
      end
      if (load_skid) begin
         skid_x_ff <= new_x;
         skid_y_ff <= new_y;
         skid_z_ff <= new_z;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = $signed(out_x_ff);
   assign rsp_point_y = $signed(out_y_ff);
   assign rsp_point_z = out_z_ff;

   `DPP_ASSERT(a_skid_needs_out, clock, reset, skid_full_ff |-> rsp_valid_ff)
   `DPP_ASSERT(a_ray_chains_agree, clock, reset, uv_valid == vv_valid)
   `DPP_ASSERT(a_point_chains_agree, clock, reset, (xv_valid == yv_valid) && (yv_valid == zv_valid))
   `DPP_ASSERT(a_skid_drains, clock, reset, (skid_full_ff && !rsp_stall) |=> !skid_full_ff)
   `DPP_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && !skid_full_ff))

endmodule

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// Depth pixel to 3D point testbench
// Drives depth pixels through the back-projection block under random
// sender gaps and receiver stalls, predicts every point in fixed point and
// compares each result field by field, across several register settings.
// ---------------------------------------------------------------------------
module tb;

   localparam int CB = 12;
   localparam int UF = dpp_pkg::FIX_TOTAL - CB;
   localparam int LATENCY = 93;
   localparam longint LIMIT = 400000;

   typedef struct packed {
      logic [dpp_pkg::COL_W-1:0]   column;
      logic [dpp_pkg::COL_W-1:0]   row;
      logic [dpp_pkg::DEPTH_W-1:0] depth;
   } pixel_type;

   typedef struct packed {
      logic [dpp_pkg::PX_W-1:0] px;
      logic [dpp_pkg::PX_W-1:0] py;
      logic [dpp_pkg::PZ_W-1:0] pz;
   } point_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [dpp_pkg::COL_W-1:0] req_column = 0;
   logic [dpp_pkg::COL_W-1:0] req_row = 0;
   logic [dpp_pkg::DEPTH_W-1:0] req_depth = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [dpp_pkg::PX_W-1:0] rsp_point_x;
   logic signed [dpp_pkg::PX_W-1:0] rsp_point_y;
   logic [dpp_pkg::PZ_W-1:0] rsp_point_z;
   logic csr_valid = 0;
   logic csr_ready;
   logic [dpp_pkg::CSR_IDX_W-1:0] csr_index = dpp_pkg::REG_CENTER_X;
   logic [dpp_pkg::CSR_DATA_W-1:0] csr_data = 0;

   depth_pixel_to_3d_point_top #(.COORD_BITS(CB)) uut (.*);

   always #6 clock = ~clock;

   // Predictor copy of the registers.
   logic [dpp_pkg::CENTER_W-1:0] cur_cx = 0, cur_cy = 0;
   logic [dpp_pkg::FOCAL_W-1:0] cur_fx = dpp_pkg::FOCAL_X_RST, cur_fy = dpp_pkg::FOCAL_Y_RST;

   pixel_type pending_pixels[$];
   point_type expected_points[$];
   int errors = 0;
   int points_seen = 0;
   longint cycles = 0;
   bit hold_req = 0;

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned ray_magnitude(longint d,
         logic [dpp_pkg::FOCAL_W-1:0] f);
      longint unsigned m, fu;
      m = (d < 0) ? -d : d;
      fu = (f < dpp_pkg::FOCAL_MIN) ? dpp_pkg::FOCAL_MIN : f;
      return ((m << (dpp_pkg::FOCAL_FRAC + UF)) + fu / 2) / fu;
   endfunction

   function automatic logic [dpp_pkg::PX_W-1:0] lateral_coord(longint unsigned dep,
         longint unsigned mag, bit neg, longint ctr, longint unsigned n);
      longint unsigned q;
      longint v;
      q = ((dep * mag << dpp_pkg::OUT_FRAC) + n / 2) / n;
      v = neg ? -longint'(q) : longint'(q);
      v += ctr * (1 << dpp_pkg::OUT_FRAC);
      return v[dpp_pkg::PX_W-1:0];
   endfunction

   function automatic point_type project_pixel(pixel_type p);
      longint cx, cy, dx, dy;
      longint unsigned um, vm, s, n, dep, qz;
      point_type r;
      cx = longint'($signed(cur_cx));
      cy = longint'($signed(cur_cy));
      dx = longint'(p.column[CB-1:0]) - cx;
      dy = longint'(p.row[CB-1:0]) - cy;
      dep = p.depth;
      um = ray_magnitude(dx, cur_fx);
      vm = ray_magnitude(dy, cur_fy);
      s = um * um + vm * vm + (64'd1 << (2 * UF));
      n = int_sqrt(s);
      r.px = lateral_coord(dep, um, dx < 0, cx, n);
      r.py = lateral_coord(dep, vm, dy < 0, cy, n);
      qz = ((dep << (dpp_pkg::OUT_FRAC + UF)) + n / 2) / n;
      r.pz = qz[dpp_pkg::PZ_W-1:0];
      return r;
   endfunction

   // Sender: bursts and gaps.
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_stall) begin
         expected_points.insert(expected_points.size(),
                                project_pixel({req_column, req_row, req_depth}));
         if (burst_left > 0 && pending_pixels.size() > 0) begin
            {req_column, req_row, req_depth} <= pending_pixels.pop_front();
            burst_left <= burst_left - 1;
         end else begin
            req_valid <= 0;
            gap_left <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
         end
      end else if (!req_valid) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_pixels.size() > 0) begin
            {req_column, req_row, req_depth} <= pending_pixels.pop_front();
            req_valid <= 1;
            burst_left <= $urandom_range(0, 40);
         end
      end
   end

   // Receiver: stall pattern plus one long hold, counted here, when asked.
   int stall_mode = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         if (hold_req && !hold_done) begin
            hold_left <= 300;
            hold_done <= 1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= (hold_left > 0);
            1: rsp_stall <= (hold_left > 0) || ($urandom_range(0, 3) == 0);
            default: rsp_stall <= (hold_left > 0) || ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // Monitor.
   always @(posedge clock) begin
      point_type exp_pt;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         points_seen <= points_seen + 1;
         if (expected_points.size() == 0) begin
            $error("unexpected point %h %h %h", rsp_point_x, rsp_point_y, rsp_point_z);
            errors++;
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_point_x !== exp_pt.px) begin
               $error("point_x expected %h actual %h", exp_pt.px, rsp_point_x);
               errors++;
            end
            if (rsp_point_y !== exp_pt.py) begin
               $error("point_y expected %h actual %h", exp_pt.py, rsp_point_y);
               errors++;
            end
            if (rsp_point_z !== exp_pt.pz) begin
               $error("point_z expected %h actual %h", exp_pt.pz, rsp_point_z);
               errors++;
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: errors");
         $finish;
      end
   end

   task automatic write_reg(logic [dpp_pkg::CSR_IDX_W-1:0] idx,
         logic [dpp_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      // Register is 13 bits for the centers; upper data bits are dropped.
      case (idx)
         dpp_pkg::REG_CENTER_X: cur_cx = val[dpp_pkg::CENTER_W-1:0];
         dpp_pkg::REG_CENTER_Y: cur_cy = val[dpp_pkg::CENTER_W-1:0];
         dpp_pkg::REG_FOCAL_X:  cur_fx = val;
         default:               cur_fy = val;
      endcase
   endtask

   task automatic drain_all();
      while (pending_pixels.size() > 0 || req_valid || expected_points.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic add_pixel(pixel_type p);
      pending_pixels.insert(pending_pixels.size(), p);
   endtask

   task automatic queue_directed();
      add_pixel('{0, 0, 0});
      add_pixel('{4095, 4095, 16'hFFFF});
      add_pixel('{0, 4095, 16'hFFFF});
      add_pixel('{4095, 0, 1});
      add_pixel('{12'hAAA, 12'h555, 16'hAAAA});
      add_pixel('{12'h555, 12'hAAA, 16'h5555});
      add_pixel('{2048, 2048, 16'hFFFF});
      add_pixel('{100, 3000, 0});
   endtask

   task automatic queue_random(int count);
      pixel_type p;
      repeat (count) begin
         p.column = dpp_pkg::COL_W'($urandom);
         p.row = dpp_pkg::COL_W'($urandom);
         case ($urandom_range(0, 4))
            0: p.depth = 0;
            1: p.depth = dpp_pkg::DEPTH_W'(16'hFFFF - $urandom_range(0, 3));
            default: p.depth = dpp_pkg::DEPTH_W'($urandom);
         endcase
         add_pixel(p);
      end
   endtask

   initial begin
      logic [dpp_pkg::CSR_DATA_W-1:0] settings[6][4];
      settings = '{
         '{16'h0000, 16'h0000, dpp_pkg::FOCAL_X_RST, dpp_pkg::FOCAL_Y_RST},
         '{16'h0FFF, 16'h1000, 16'd16, 16'hFFFF},
         '{16'h1000, 16'h0FFF, 16'hFFFF, 16'd16},
         '{16'hF800, 16'h0640, 16'd0, 16'd5},
         '{16'd320, 16'd240, 16'd11891, 16'd11874},
         '{16'h1FFF, 16'hE001, 16'd1000, 16'd40000}
      };
      repeat (2) @(posedge clock);
      reset <= 0;
      queue_directed();
      drain_all();
      for (int k = 0; k < 6; k++) begin
         for (int r = 0; r < 4; r++)
            write_reg(r[dpp_pkg::CSR_IDX_W-1:0], settings[k][r]);
         queue_directed();
         if (k == 2) begin
            // Enough items to fill the pipeline while the receiver holds off.
            queue_random(150);
            hold_req = 1;
         end else begin
            queue_random(50);
         end
         drain_all();
      end
      repeat (LATENCY + 20) @(posedge clock);
      $display("covered %0d points over 7 register settings, incl. extremes", points_seen);
      $display("and a long receiver hold that backed up the input");
      if (errors == 0 && expected_points.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
